[rtl/grfw_pkg.sv]
// Shared types and constants for the glyph row framebuffer writer.
// Holds the beat structs, the queued command and the display geometry.
// No dependencies.
`timescale 1ns / 1ps

package grfw_pkg;

  // Display geometry: bytes per pixel line in 8bpp, half that in 4bpp.
  localparam int PIXELS_PER_LINE = 320;
  localparam int LINE_BYTES_8BPP = PIXELS_PER_LINE;
  localparam int LINE_BYTES_4BPP = PIXELS_PER_LINE / 2;
  localparam int GLYPH_ROWS      = 8;

  localparam int ADDR_W = 17;

  // Writes per character and cursor step per character.
  localparam int BEATS_8BPP = 64;
  localparam int BEATS_4BPP = 32;
  localparam int STEP_8BPP  = 8;
  localparam int STEP_4BPP  = 4;

  // Colour depth codes; the other two codes write nothing.
  localparam logic [1:0] DEPTH_4BPP  = 2'd2;
  localparam logic [1:0] DEPTH_8BPP  = 2'd3;
  localparam logic [1:0] DEPTH_RESET = DEPTH_8BPP;

  // Nibble and byte written for a clear glyph bit (white).
  localparam logic [3:0] WHITE_NIBBLE = 4'hF;
  localparam logic [7:0] WHITE_BYTE   = 8'hFF;

  typedef struct packed {
    logic [63:0] glyph_bits;
    logic        start_of_text;
    logic [8:0]  start_x;
    logic [4:0]  text_row;
    logic [3:0]  color;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] mem_address;
    logic [7:0]        write_data;
    logic              last_write;
  } out_item_t;

  // One character ready for rendering.
  typedef struct packed {
    logic [63:0]       glyph_bits;
    logic [3:0]        color;
    logic [ADDR_W-1:0] base;
    logic              mode_8bpp;
  } cmd_t;

endpackage

[rtl/glyph_row_framebuffer_writer.sv]
// Top level of the glyph row framebuffer writer: front end, command queue
// and back end. Depends on grfw_pkg, grfw_front, grfw_cmd_q and grfw_back.
//
// Each pushed 8x8 glyph becomes 64 byte writes in 8bpp mode (depth code 3) or
// 32 in 4bpp mode (depth code 2), popped one per cycle while the output buffer
// holds writes and pop is high, in address order, with last_write set on the
// final one; other depth codes produce nothing but still load the cursor. The
// back end issues one write per clock while its output buffer has room. A
// two-entry command queue lets the next glyphs be pushed while the current one
// is still being written, and a two-entry output buffer keeps writes flowing
// while pop is held low.
// The depth register should only be written while no writes are pending.
`timescale 1ns / 1ps

module glyph_row_framebuffer_writer import grfw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  in_item_t   in_item,
  output logic       out_empty,
  input  logic       out_pop,
  output out_item_t  out_item,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data
);

  logic in_accept;
  logic cmd_push;
  logic cmd_full;
  logic cmd_pop;
  logic cmd_empty;
  cmd_t cmd_in;
  cmd_t cmd_head;

  assign in_full   = cmd_full;
  assign in_accept = in_push && !cmd_full;
  assign cfg_ready = 1'b1;

  grfw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_item   (in_item),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd_push  (cmd_push),
    .cmd_data  (cmd_in)
  );

  grfw_cmd_q u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .empty     (cmd_empty),
    .head      (cmd_head)
  );

  grfw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_head  (cmd_head),
    .cmd_pop   (cmd_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_item)
  );

endmodule

[rtl/grfw_front.sv]
// Front end of the glyph row framebuffer writer: takes input beats, keeps the
// cursor and the depth register, and turns each character into a command when the depth code renders.
// Depends on grfw_pkg.
`timescale 1ns / 1ps

module grfw_front import grfw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_accept,
  input  in_item_t in_item,
  input  logic     cfg_write,
  input  logic [1:0] cfg_data,
  output logic     cmd_push,
  output cmd_t     cmd_data
);

  logic [ADDR_W-1:0] cursor_r, cursor_nxt;
  logic [4:0]        text_row_r, text_row_nxt;
  logic [1:0]        depth_r, depth_nxt;

  logic [ADDR_W-1:0] cur_base;
  logic [4:0]        row_base;
  logic              render;
  logic              mode_8bpp;
  logic [ADDR_W-1:0] row_offset;

  // Cursor and text row as seen by this character, after any load.
  always_comb begin
    cur_base  = in_item.start_of_text ? ADDR_W'(in_item.start_x) : cursor_r;
    row_base  = in_item.start_of_text ? in_item.text_row : text_row_r;
    mode_8bpp = (depth_r == DEPTH_8BPP);
    render    = (depth_r == DEPTH_8BPP) || (depth_r == DEPTH_4BPP);
    if (mode_8bpp) begin
      row_offset = ADDR_W'(32'(row_base) * (GLYPH_ROWS * LINE_BYTES_8BPP));
    end else begin
      row_offset = ADDR_W'(32'(row_base) * (GLYPH_ROWS * LINE_BYTES_4BPP));
    end
  end

  // Command for the back end.
  always_comb begin
    cmd_push            = in_accept && render;
    cmd_data.glyph_bits = in_item.glyph_bits;
    cmd_data.color      = in_item.color;
    cmd_data.base       = cur_base + row_offset;
    cmd_data.mode_8bpp  = mode_8bpp;
  end

  // State update: the load always happens, the advance only when rendering.
  always_comb begin
    cursor_nxt   = cursor_r;
    text_row_nxt = text_row_r;
    depth_nxt    = depth_r;
    if (in_accept) begin
      text_row_nxt = row_base;
      if (!render) begin
        cursor_nxt = cur_base;
      end else if (mode_8bpp) begin
        cursor_nxt = cur_base + ADDR_W'(STEP_8BPP);
      end else begin
        cursor_nxt = cur_base + ADDR_W'(STEP_4BPP);
      end
    end
    if (cfg_write) begin
      depth_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r   <= '0;
      text_row_r <= '0;
      depth_r    <= DEPTH_RESET;
    end else begin
      cursor_r   <= cursor_nxt;
      text_row_r <= text_row_nxt;
      depth_r    <= depth_nxt;
    end
  end

endmodule

[rtl/grfw_cmd_q.sv]
// Two-entry command queue between front and back end of the glyph writer.
// Lets either side stall on its own. Depends on grfw_pkg.
`timescale 1ns / 1ps

module grfw_cmd_q import grfw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  cmd_t       entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign head  = entry_r[rd_ptr_r];

  // Pointer and fill count bookkeeping.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Payload storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("command queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop) else $error("command queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3) else $error("command queue count out of range");
`endif

endmodule

[rtl/grfw_back.sv]
// Back end of the glyph writer: walks the rows and bytes of one command,
// one framebuffer write per cycle into a two-entry output buffer while it has room.
// Depends on grfw_pkg.
`timescale 1ns / 1ps

module grfw_back import grfw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_empty,
  input  cmd_t      cmd_head,
  output logic      cmd_pop,
  input  logic      out_pop,
  output logic      out_empty,
  output out_item_t out_item
);

  logic [5:0]  idx_r, idx_nxt;
  out_item_t   obuf_r [2];
  logic        ob_wr_r, ob_wr_nxt;
  logic        ob_rd_r, ob_rd_nxt;
  logic [1:0]  ob_cnt_r, ob_cnt_nxt;

  logic              produce;
  logic              take;
  logic              is_last;
  logic [2:0]        row;
  logic [2:0]        byte_sel;
  logic [7:0]        line;
  logic [ADDR_W-1:0] row_offset;
  logic [3:0]        hi_nib;
  logic [3:0]        lo_nib;
  out_item_t         beat;

  // Row and byte position of the current write.
  always_comb begin
    if (cmd_head.mode_8bpp) begin
      row        = idx_r[5:3];
      byte_sel   = idx_r[2:0];
      is_last    = (idx_r == 6'(BEATS_8BPP - 1));
      row_offset = ADDR_W'(32'(row) * LINE_BYTES_8BPP);
    end else begin
      row        = idx_r[4:2];
      byte_sel   = {1'b0, idx_r[1:0]};
      is_last    = (idx_r[4:0] == 5'(BEATS_4BPP - 1));
      row_offset = ADDR_W'(32'(row) * LINE_BYTES_4BPP);
    end
  end

  // Pixel data: row 0 sits in the top byte, the MSB is the leftmost pixel.
  always_comb begin
    line   = cmd_head.glyph_bits[{~row, 3'b000} +: 8];
    hi_nib = line[~{byte_sel[1:0], 1'b0}] ? cmd_head.color : WHITE_NIBBLE;
    lo_nib = line[~{byte_sel[1:0], 1'b1}] ? cmd_head.color : WHITE_NIBBLE;
    beat.mem_address = cmd_head.base + row_offset + ADDR_W'(byte_sel);
    beat.last_write  = is_last;
    if (cmd_head.mode_8bpp) begin
      beat.write_data = line[~byte_sel] ? {4'h0, cmd_head.color} : WHITE_BYTE;
    end else begin
      beat.write_data = {hi_nib, lo_nib};
    end
  end

  // Issue a write whenever a command waits and the buffer has room.
  always_comb begin
    produce    = !cmd_empty && (ob_cnt_r != 2'd2);
    take       = out_pop && (ob_cnt_r != 2'd0);
    cmd_pop    = produce && is_last;
    idx_nxt    = idx_r;
    if (produce) begin
      idx_nxt = is_last ? 6'd0 : idx_r + 6'd1;
    end
    ob_wr_nxt  = ob_wr_r ^ produce;
    ob_rd_nxt  = ob_rd_r ^ take;
    ob_cnt_nxt = ob_cnt_r + 2'(produce) - 2'(take);
  end

  assign out_empty = (ob_cnt_r == 2'd0);
  assign out_item  = obuf_r[ob_rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      ob_wr_r  <= 1'b0;
      ob_rd_r  <= 1'b0;
      ob_cnt_r <= 2'd0;
    end else begin
      idx_r    <= idx_nxt;
      ob_wr_r  <= ob_wr_nxt;
      ob_rd_r  <= ob_rd_nxt;
      ob_cnt_r <= ob_cnt_nxt;
    end
  end

  // Output buffer payload.
  always_ff @(posedge clk) begin
    if (produce) begin
      obuf_r[ob_wr_r] <= beat;
    end
  end

`ifndef NO_ASSERTIONS
  a_buf_range: assert property (@(posedge clk) disable iff (!rst_n)
    ob_cnt_r != 2'd3) else $error("output buffer count out of range");
  a_idle_index: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_empty |-> idx_r == 6'd0) else $error("write index moved with no command");
  a_4bpp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (!cmd_empty && !cmd_head.mode_8bpp) |-> !idx_r[5])
    else $error("4bpp write index beyond the character");
`endif

endmodule

[tb/grfw_tb_pkg.sv]
// Scoreboard for the glyph row framebuffer writer testbench: a predictor of the
// framebuffer writes each glyph causes, and the store of writes still owed.
// Depends on grfw_pkg for the beat structs, depth codes and display geometry.
`timescale 1ns / 1ps

package grfw_tb_pkg;
  import grfw_pkg::*;

  // The two depth codes that write nothing.
  localparam logic [1:0] DEPTH_NONE_0 = 2'd0;
  localparam logic [1:0] DEPTH_NONE_1 = 2'd1;

  // Only the first few mismatches are printed; all of them are counted.
  localparam int unsigned REPORT_CAP = 40;

  class write_scoreboard;
    logic [1:0]        depth;
    logic [ADDR_W-1:0] cursor;
    logic [4:0]        text_line;
    out_item_t         pending_writes[$];
    int unsigned       writes_checked;
    int unsigned       mismatches;

    function new();
      depth          = DEPTH_RESET;
      cursor         = '0;
      text_line      = '0;
      writes_checked = 0;
      mismatches     = 0;
    endfunction

    function void set_depth(logic [1:0] code);
      depth = code;
    endfunction

    function int unsigned outstanding();
      return pending_writes.size();
    endfunction

    // Works out every write an accepted glyph beat causes, in address order.
    function void note_glyph(in_item_t it);
      int unsigned stride;
      int unsigned per_row;
      int unsigned base;
      logic [7:0]  line;
      logic [7:0]  data;
      logic [3:0]  hi;
      logic [3:0]  lo;
      out_item_t   w;
      // The cursor is loaded even when the depth code writes nothing.
      if (it.start_of_text) begin
        cursor    = ADDR_W'(it.start_x);
        text_line = it.text_row;
      end
      // Bytes per glyph row equal the cursor step in both modes.
      if (depth == DEPTH_8BPP) begin
        stride  = LINE_BYTES_8BPP;
        per_row = STEP_8BPP;
      end else if (depth == DEPTH_4BPP) begin
        stride  = LINE_BYTES_4BPP;
        per_row = STEP_4BPP;
      end else begin
        return;
      end
      base = cursor + text_line * GLYPH_ROWS * stride;
      for (int unsigned row = 0; row < GLYPH_ROWS; row++) begin
        line = it.glyph_bits[63 - 8 * row -: 8];
        for (int unsigned b = 0; b < per_row; b++) begin
          if (per_row == STEP_8BPP) begin
            data = line[7 - b] ? {4'h0, it.color} : WHITE_BYTE;
          end else begin
            // The left pixel of the pair sits in the high nibble.
            hi   = line[7 - 2 * b] ? it.color : WHITE_NIBBLE;
            lo   = line[6 - 2 * b] ? it.color : WHITE_NIBBLE;
            data = {hi, lo};
          end
          w.mem_address = ADDR_W'(base + row * stride + b);
          w.write_data  = data;
          w.last_write  = (row == GLYPH_ROWS - 1) && (b == per_row - 1);
          pending_writes.push_back(w);
        end
      end
      cursor = cursor + ADDR_W'(per_row);
    endfunction

    task report(string msg);
      if (mismatches < REPORT_CAP) begin
        $display("[%0t] mismatch: %s", $realtime, msg);
      end
      mismatches++;
    endtask

    // Compares one accepted write beat with the oldest one owed.
    task check_write(out_item_t got);
      out_item_t want;
      if (pending_writes.size() == 0) begin
        report($sformatf("write addr %h data %h with nothing owed",
                         got.mem_address, got.write_data));
        return;
      end
      want = pending_writes.pop_front();
      if (got.mem_address !== want.mem_address) begin
        report($sformatf("write %0d: mem_address %h, want %h",
                         writes_checked, got.mem_address, want.mem_address));
      end
      if (got.write_data !== want.write_data) begin
        report($sformatf("write %0d (addr %h): write_data %h, want %h",
                         writes_checked, want.mem_address, got.write_data,
                         want.write_data));
      end
      if (got.last_write !== want.last_write) begin
        report($sformatf("write %0d (addr %h): last_write %b, want %b",
                         writes_checked, want.mem_address, got.last_write,
                         want.last_write));
      end
      writes_checked++;
    endtask
  endclass

endpackage

[tb/glyph_row_framebuffer_writer_tb.sv]
// Top of the glyph row framebuffer writer testbench: clock, reset, glyph and
// depth drivers, write consumer and run control. Depends on grfw_pkg, on
// grfw_tb_pkg for the scoreboard and on the glyph_row_framebuffer_writer RTL.
`timescale 1ns / 1ps

module glyph_row_framebuffer_writer_tb;
  import grfw_pkg::*;
  import grfw_tb_pkg::*;

  localparam int unsigned ITEM_TARGET   = 450;
  localparam int unsigned PHASE_ITEMS   = 56;
  localparam int unsigned BLANK_ITEMS   = 8;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT   = 2500000;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_push   = 1'b0;
  logic      in_full;
  in_item_t  in_item   = '0;
  logic      out_empty;
  logic      out_pop   = 1'b0;
  out_item_t out_item;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [1:0] cfg_data = '0;

  write_scoreboard sb = new();

  // When set, neither side idles between beats.
  bit          calm = 1'b0;
  int unsigned glyphs_sent = 0;
  int unsigned depth_writes = 0;
  int unsigned cycles = 0;

  glyph_row_framebuffer_writer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Cycles to idle before the next beat on either side.
  function automatic int unsigned draw_gap();
    if (calm || $urandom_range(0, 3) == 0) begin
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  function automatic in_item_t glyph_item(logic [63:0] glyph, logic fresh,
                                          logic [8:0] x, logic [4:0] row,
                                          logic [3:0] colour);
    in_item_t it;
    it.glyph_bits    = glyph;
    it.start_of_text = fresh;
    it.start_x       = x;
    it.text_row      = row;
    it.color         = colour;
    return it;
  endfunction

  // Random bitmaps half the time, with blank, solid, sparse and dense ones mixed in.
  function automatic logic [63:0] make_glyph();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return {$urandom & $urandom & $urandom, $urandom & $urandom & $urandom};
      3: return {$urandom | $urandom, $urandom | $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Positions stay on screen most of the time, with the odd one beyond it.
  function automatic in_item_t random_item(bit fresh);
    logic [8:0] x;
    logic [4:0] row;
    x   = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(320, 511))
                                      : 9'($urandom_range(0, 319));
    row = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(30, 31))
                                      : 5'($urandom_range(0, 29));
    return glyph_item(make_glyph(), fresh, x, row, 4'($urandom_range(0, 15)));
  endfunction

  // Presents one glyph beat and notes it once it has been taken.
  task automatic send_glyph(in_item_t it);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_full !== 1'b0);
    sb.note_glyph(it);
    glyphs_sent++;
  endtask

  // Holds the input back until every owed write has been popped, then idles
  // so that the block settles.
  task automatic settle();
    in_push <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_depth(logic [1:0] code);
    cfg_valid <= 1'b1;
    cfg_data  <= code;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    sb.set_depth(code);
    depth_writes++;
  endtask

  // Write consumer: pops with random stalls between beats.
  initial begin
    int unsigned stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty !== 1'b0);
    end
  end

  // Every accepted write beat goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_pop === 1'b1 && out_empty === 1'b0) begin
      sb.check_write(out_item);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL glyph_row_framebuffer_writer");
      $finish;
    end
  end

  initial begin
    logic [1:0]  depth_plan[6];
    logic [1:0]  code;
    int unsigned directed;
    int unsigned phases;
    int unsigned n;
    int unsigned len;
    int unsigned k;
    int unsigned quota;

    depth_plan = '{DEPTH_4BPP, DEPTH_8BPP, DEPTH_NONE_0,
                   DEPTH_8BPP, DEPTH_4BPP, DEPTH_NONE_1};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed glyphs in the reset depth (8bpp): blank, solid, corner pixels,
    // stripes, colour 0 against white, and a position off the screen.
    send_glyph(glyph_item('0, 1'b1, 9'd0, 5'd0, 4'd0));
    send_glyph(glyph_item('1, 1'b0, 9'd0, 5'd0, 4'd15));
    send_glyph(glyph_item(64'h8000_0000_0000_0001, 1'b0, 9'd0, 5'd0, 4'd5));
    send_glyph(glyph_item(64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 9'd319, 5'd29, 4'd10));
    send_glyph(glyph_item(64'h5555_5555_5555_5555, 1'b0, 9'd0, 5'd0, 4'd0));
    send_glyph(glyph_item(64'h0123_4567_89AB_CDEF, 1'b1, 9'd511, 5'd31, 4'd15));

    // The same shapes in 4bpp, where pixels pair up into nibbles.
    settle();
    write_depth(DEPTH_4BPP);
    send_glyph(glyph_item('1, 1'b1, 9'd0, 5'd0, 4'd15));
    send_glyph(glyph_item('0, 1'b0, 9'd0, 5'd0, 4'd3));
    send_glyph(glyph_item(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 9'd0, 5'd0, 4'd12));
    send_glyph(glyph_item(64'h5555_5555_5555_5555, 1'b0, 9'd0, 5'd0, 4'd9));
    send_glyph(glyph_item(64'hF0F0_0F0F_C3C3_3C3C, 1'b1, 9'd511, 5'd31, 4'd0));

    // Depth codes that write nothing still load the cursor but never move it;
    // the 8bpp glyphs after them show where it was left.
    settle();
    write_depth(DEPTH_NONE_0);
    send_glyph(glyph_item('1, 1'b1, 9'd100, 5'd5, 4'd7));
    send_glyph(glyph_item('1, 1'b0, 9'd0, 5'd0, 4'd7));
    settle();
    write_depth(DEPTH_NONE_1);
    send_glyph(glyph_item(64'hFF00_FF00_FF00_FF00, 1'b1, 9'd200, 5'd7, 4'd1));
    settle();
    write_depth(DEPTH_8BPP);
    send_glyph(glyph_item(64'h1818_3C7E_FF7E_3C18, 1'b0, 9'd0, 5'd0, 4'd6));
    send_glyph(glyph_item(64'h8142_2418_1824_4281, 1'b0, 9'd0, 5'd0, 4'd11));
    directed = glyphs_sent;

    // Random phases of text strings, each in its own depth; some phases run
    // with no idling on either side. Phases that write nothing are short, and
    // the last phase is cut so that the run sends the item total.
    phases = 0;
    while (glyphs_sent < ITEM_TARGET) begin
      code = depth_plan[phases % 6];
      settle();
      write_depth(code);
      calm  = (phases % 3 == 2);
      quota = (code == DEPTH_4BPP || code == DEPTH_8BPP) ? PHASE_ITEMS : BLANK_ITEMS;
      if (quota > ITEM_TARGET - glyphs_sent) begin
        quota = ITEM_TARGET - glyphs_sent;
      end
      n = 0;
      while (n < quota) begin
        len = $urandom_range(1, 20);
        // A string opens with a cursor load; a stray load mid-string is noise.
        for (k = 0; k < len && n < quota; k++) begin
          send_glyph(random_item(k == 0 || $urandom_range(0, 15) == 0));
          n++;
        end
      end
      phases++;
    end
    calm = 1'b0;

    settle();
    $display("Sent %0d glyphs (%0d directed) over %0d random phases with %0d depth writes.",
             glyphs_sent, directed, phases, depth_writes);
    $display("Checked %0d framebuffer writes, %0d mismatches.",
             sb.writes_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("PASS glyph_row_framebuffer_writer");
    end else begin
      $display("FAIL glyph_row_framebuffer_writer");
    end
    $finish;
  end

endmodule
